// ----- sv/vpp_pkg.sv -----
// ----------------------------------------------------------------------------
// vpp_pkg: shared types and constants for the vertex projection pipeline
// Widths, register codes and stage payload structs.
// ----------------------------------------------------------------------------
`default_nettype none
package vpp_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int MAX_IMAGE_DIM   = 4096;

    localparam int COORD_W  = 32;
    localparam int CFG_W    = 64;
    localparam int IDX_W    = 4;
    localparam int DIM_W    = 13;
    localparam int PIX_W    = 16;

    localparam int PROD_W   = 2 * COORD_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int CORE_W   = SUM_W + 1;
    localparam int CL_W     = 34;
    localparam int CH_W     = CORE_W - CL_W;
    localparam int PL_W     = CL_W + DIM_W;
    localparam int PH_W     = CH_W + DIM_W + 1;
    localparam int N_W      = CORE_W + DIM_W + 2;
    localparam int D_W      = SUM_W + 2;
    localparam int REM_W    = N_W + PIX_W;
    localparam int DIV_STEPS = PIX_W;

    localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
    localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] ONE_Q = COORD_W'(1) << COORD_FRAC_BITS;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW_X_LO = 4'd0,
        REG_ROW_X_HI = 4'd1,
        REG_ROW_Y_LO = 4'd2,
        REG_ROW_Y_HI = 4'd3,
        REG_ROW_W_LO = 4'd4,
        REG_ROW_W_HI = 4'd5,
        REG_IMG_W    = 4'd6,
        REG_IMG_H    = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
    } vertex_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_col;
        logic signed [PIX_W-1:0] pixel_row;
        logic                    clipped;
        logic                    zero_w;
    } pixel_t;

    // coef[row][col]: rows x, y, w; cols vertex x, y, z, constant
    typedef struct packed {
        logic [2:0][3:0][COORD_W-1:0] coef;
        logic [DIM_W-1:0]             dim_w;
        logic [DIM_W-1:0]             dim_h;
    } cfg_t;

    typedef struct packed {
        logic signed [CORE_W-1:0] core_x;
        logic signed [CORE_W-1:0] core_y;
        logic signed [SUM_W-1:0]  w;
    } core_t;

    typedef struct packed {
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
        logic [REM_W-1:0] dsh;
        logic [PIX_W-1:0] q_x;
        logic [PIX_W-1:0] q_y;
        logic             hi_x;
        logic             lo_x;
        logic             hi_y;
        logic             lo_y;
        logic             zero_w;
    } div_t;

endpackage
`default_nettype wire

// ----- sv/vpp_transform.sv -----
// ----------------------------------------------------------------------------
// vpp_transform: matrix rows times homogeneous vertex
// Three stages: products, row sums, viewport cores (w+x, w-y).
// ----------------------------------------------------------------------------
`default_nettype none
module vpp_transform (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire vpp_pkg::cfg_t  cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire vpp_pkg::vertex_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output vpp_pkg::core_t      out_data
);
    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    logic signed [vpp_pkg::PROD_W-1:0] p_reg  [3][4];
    logic signed [vpp_pkg::PROD_W-1:0] p_next [3][4];
    logic signed [vpp_pkg::SUM_W-1:0]  s_reg  [3];
    logic signed [vpp_pkg::SUM_W-1:0]  s_next [3];
    vpp_pkg::core_t core_reg, core_next;
    logic signed [vpp_pkg::COORD_W-1:0] vin [3];

    assign r3 = !v3_reg || out_ready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready  = r1;
    assign out_valid = v3_reg;
    assign out_data  = core_reg;

    assign vin[0] = in_data.vertex_x;
    assign vin[1] = in_data.vertex_y;
    assign vin[2] = in_data.vertex_z;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                p_next[r][c] = $signed(cfg.coef[r][c]) * vin[c];
            end
            // constant column: coefficient times 1.0 is a shift
            p_next[r][3] = vpp_pkg::PROD_W'($signed(cfg.coef[r][3]))
                           <<< vpp_pkg::COORD_FRAC_BITS;
        end
        for (int r = 0; r < 3; r++) begin
            s_next[r] = vpp_pkg::SUM_W'(p_reg[r][0]) + vpp_pkg::SUM_W'(p_reg[r][1])
                      + vpp_pkg::SUM_W'(p_reg[r][2]) + vpp_pkg::SUM_W'(p_reg[r][3]);
        end
        core_next.core_x = vpp_pkg::CORE_W'(s_reg[2]) + vpp_pkg::CORE_W'(s_reg[0]);
        core_next.core_y = vpp_pkg::CORE_W'(s_reg[2]) - vpp_pkg::CORE_W'(s_reg[1]);
        core_next.w      = s_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
        if (r1 && in_valid) p_reg <= p_next;
        if (r2 && v1_reg)   s_reg <= s_next;
        if (r3 && v2_reg)   core_reg <= core_next;
    end

endmodule
`default_nettype wire

// ----- sv/vpp_setup.sv -----
// ----------------------------------------------------------------------------
// vpp_setup: numerator and divisor setup for the viewport divide
// Scale by image size, normalize divisor sign, range-check and bias.
// ----------------------------------------------------------------------------
`default_nettype none
module vpp_setup (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [vpp_pkg::DIM_W-1:0] dim_w,
    input  wire logic [vpp_pkg::DIM_W-1:0] dim_h,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire vpp_pkg::core_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output vpp_pkg::div_t        out_data
);
    typedef struct packed {
        logic [vpp_pkg::PL_W-1:0]        pl_x;
        logic signed [vpp_pkg::PH_W-1:0] ph_x;
        logic [vpp_pkg::PL_W-1:0]        pl_y;
        logic signed [vpp_pkg::PH_W-1:0] ph_y;
        logic signed [vpp_pkg::SUM_W-1:0] w;
    } part_t;

    typedef struct packed {
        logic signed [vpp_pkg::N_W-1:0] n_x;
        logic signed [vpp_pkg::N_W-1:0] n_y;
        logic signed [vpp_pkg::D_W-1:0] d;
        logic                           zero_w;
    } frac_t;

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;
    part_t part_reg, part_next;
    frac_t frac_reg, frac_next;
    vpp_pkg::div_t div_reg, div_next;

    logic signed [vpp_pkg::N_W-1:0]   nx_raw, ny_raw;
    logic signed [vpp_pkg::D_W-1:0]   d_raw;
    logic signed [vpp_pkg::REM_W-1:0] nxe, nye, dhs;

    assign r3 = !v3_reg || out_ready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready  = r1;
    assign out_valid = v3_reg;
    assign out_data  = div_reg;

    always_comb begin
        // core * dim split into two partial products
        part_next.pl_x = vpp_pkg::PL_W'(in_data.core_x[vpp_pkg::CL_W-1:0])
                       * vpp_pkg::PL_W'(dim_w);
        part_next.ph_x = vpp_pkg::PH_W'($signed(in_data.core_x[vpp_pkg::CORE_W-1:vpp_pkg::CL_W]))
                       * vpp_pkg::PH_W'($signed({1'b0, dim_w}));
        part_next.pl_y = vpp_pkg::PL_W'(in_data.core_y[vpp_pkg::CL_W-1:0])
                       * vpp_pkg::PL_W'(dim_h);
        part_next.ph_y = vpp_pkg::PH_W'($signed(in_data.core_y[vpp_pkg::CORE_W-1:vpp_pkg::CL_W]))
                       * vpp_pkg::PH_W'($signed({1'b0, dim_h}));
        part_next.w    = in_data.w;

        // n = dim*core + w, d = 2w; flip both when d is negative
        nx_raw = (vpp_pkg::N_W'(part_reg.ph_x) <<< vpp_pkg::CL_W)
               + vpp_pkg::N_W'($signed({1'b0, part_reg.pl_x}))
               + vpp_pkg::N_W'(part_reg.w);
        ny_raw = (vpp_pkg::N_W'(part_reg.ph_y) <<< vpp_pkg::CL_W)
               + vpp_pkg::N_W'($signed({1'b0, part_reg.pl_y}))
               + vpp_pkg::N_W'(part_reg.w);
        d_raw  = vpp_pkg::D_W'(part_reg.w) <<< 1;
        if (d_raw < 0) begin
            frac_next.n_x = -nx_raw;
            frac_next.n_y = -ny_raw;
            frac_next.d   = -d_raw;
        end else begin
            frac_next.n_x = nx_raw;
            frac_next.n_y = ny_raw;
            frac_next.d   = d_raw;
        end
        frac_next.zero_w = (part_reg.w == '0);

        // in range iff -2^15*d <= n < 2^15*d; bias by 2^15*d
        dhs = vpp_pkg::REM_W'(frac_reg.d) <<< (vpp_pkg::PIX_W - 1);
        nxe = vpp_pkg::REM_W'(frac_reg.n_x);
        nye = vpp_pkg::REM_W'(frac_reg.n_y);
        div_next.hi_x   = (nxe >= dhs);
        div_next.lo_x   = (nxe < -dhs);
        div_next.hi_y   = (nye >= dhs);
        div_next.lo_y   = (nye < -dhs);
        div_next.rem_x  = vpp_pkg::REM_W'(nxe + dhs);
        div_next.rem_y  = vpp_pkg::REM_W'(nye + dhs);
        div_next.dsh    = vpp_pkg::REM_W'(dhs);
        div_next.q_x    = '0;
        div_next.q_y    = '0;
        div_next.zero_w = frac_reg.zero_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
        if (r1 && in_valid) part_reg <= part_next;
        if (r2 && v1_reg)   frac_reg <= frac_next;
        if (r3 && v2_reg)   div_reg  <= div_next;
    end

endmodule
`default_nettype wire

// ----- sv/vpp_div_stage.sv -----
// ----------------------------------------------------------------------------
// vpp_div_stage: one restoring-division step for both axes
// Compare against the shifted divisor, subtract, shift in a quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none
module vpp_div_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire vpp_pkg::div_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output vpp_pkg::div_t      out_data
);
    logic valid_reg;
    vpp_pkg::div_t data_reg, data_next;
    logic gx, gy;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        gx = (in_data.rem_x >= in_data.dsh);
        gy = (in_data.rem_y >= in_data.dsh);
        data_next       = in_data;
        data_next.rem_x = gx ? in_data.rem_x - in_data.dsh : in_data.rem_x;
        data_next.rem_y = gy ? in_data.rem_y - in_data.dsh : in_data.rem_y;
        data_next.q_x   = {in_data.q_x[vpp_pkg::PIX_W-2:0], gx};
        data_next.q_y   = {in_data.q_y[vpp_pkg::PIX_W-2:0], gy};
        data_next.dsh   = in_data.dsh >> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ----- sv/vertex_project_to_pixel.sv -----
// Stages: 23 register stages (3 transform, 3 setup, 16 divide steps,
//   1 output stage).
// Throughput: one vertex per cycle while the output is not stalled; each pipeline
//   stage holds its request while stalled and bubbles close up under a blocked output.
// Reset: aresetn synchronous, active low; clears all stage valids and loads
//   the identity-style default matrix and a 640x480 viewport.
// ----------------------------------------------------------------------------
// vertex_project_to_pixel: perspective vertex to viewport pixel
// Matrix transform, exact divide by w, round-half-up and 16-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module vertex_project_to_pixel (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [vpp_pkg::IDX_W-1:0]   cfg_wr_index,
    input  wire logic [vpp_pkg::CFG_W-1:0]   cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire vpp_pkg::vertex_t            s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output vpp_pkg::pixel_t                  m_data
);
    vpp_pkg::cfg_t cfg_reg;
    logic [vpp_pkg::DIM_W-1:0] dim_next;

    // config writes; image dims are clamped to the max once, at write time
    always_comb begin
        if (32'(cfg_wr_data[vpp_pkg::DIM_W-1:0]) > vpp_pkg::MAX_IMAGE_DIM) begin
            dim_next = vpp_pkg::DIM_W'(vpp_pkg::MAX_IMAGE_DIM);
        end else begin
            dim_next = cfg_wr_data[vpp_pkg::DIM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // rows w, y, x from the top: w = constant, y = vertex y, x = vertex x
            cfg_reg <= '{
                coef:  {vpp_pkg::ONE_Q, {5{32'd0}}, vpp_pkg::ONE_Q, {4{32'd0}},
                        vpp_pkg::ONE_Q},
                dim_w: vpp_pkg::DIM_W'(640),
                dim_h: vpp_pkg::DIM_W'(480)
            };
        end else if (cfg_wr_en) begin
            case (vpp_pkg::reg_idx_t'(cfg_wr_index))
                vpp_pkg::REG_ROW_X_LO: cfg_reg.coef[0][1:0] <= cfg_wr_data;
                vpp_pkg::REG_ROW_X_HI: cfg_reg.coef[0][3:2] <= cfg_wr_data;
                vpp_pkg::REG_ROW_Y_LO: cfg_reg.coef[1][1:0] <= cfg_wr_data;
                vpp_pkg::REG_ROW_Y_HI: cfg_reg.coef[1][3:2] <= cfg_wr_data;
                vpp_pkg::REG_ROW_W_LO: cfg_reg.coef[2][1:0] <= cfg_wr_data;
                vpp_pkg::REG_ROW_W_HI: cfg_reg.coef[2][3:2] <= cfg_wr_data;
                vpp_pkg::REG_IMG_W:    cfg_reg.dim_w <= dim_next;
                vpp_pkg::REG_IMG_H:    cfg_reg.dim_h <= dim_next;
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // front end: x, y, w rows and the viewport cores
    logic           tf_valid, tf_ready;
    vpp_pkg::core_t tf_data;

    vpp_transform u_transform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (tf_valid),
        .out_ready (tf_ready),
        .out_data  (tf_data)
    );

    // numerator n = dim*(w +/- coord) + w over divisor 2w, biased for the divide
    logic          dv_valid [vpp_pkg::DIV_STEPS+1];
    logic          dv_ready [vpp_pkg::DIV_STEPS+1];
    vpp_pkg::div_t dv_data  [vpp_pkg::DIV_STEPS+1];

    vpp_setup u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dim_w     (cfg_reg.dim_w),
        .dim_h     (cfg_reg.dim_h),
        .in_valid  (tf_valid),
        .in_ready  (tf_ready),
        .in_data   (tf_data),
        .out_valid (dv_valid[0]),
        .out_ready (dv_ready[0]),
        .out_data  (dv_data[0])
    );

    // one quotient bit per stage, MSB first; quotient is biased by 2^15
    for (genvar i = 0; i < vpp_pkg::DIV_STEPS; i++) begin : g_div
        vpp_div_stage u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv_valid[i]),
            .in_ready  (dv_ready[i]),
            .in_data   (dv_data[i]),
            .out_valid (dv_valid[i+1]),
            .out_ready (dv_ready[i+1]),
            .out_data  (dv_data[i+1])
        );
    end

    // output register: un-bias, saturate, zero-w override
    vpp_pkg::div_t   fin;
    vpp_pkg::pixel_t out_reg, out_next;
    logic            out_valid_reg;
    logic            out_load;

    assign fin      = dv_data[vpp_pkg::DIV_STEPS];
    assign out_load = !out_valid_reg || m_ready;
    assign dv_ready[vpp_pkg::DIV_STEPS] = out_load;

    always_comb begin
        out_next = '0;
        if (fin.zero_w) begin
            out_next.zero_w = 1'b1;
        end else begin
            if (fin.hi_x)      out_next.pixel_col = vpp_pkg::PIX_MAX;
            else if (fin.lo_x) out_next.pixel_col = vpp_pkg::PIX_MIN;
            else               out_next.pixel_col = $signed(fin.q_x ^ vpp_pkg::PIX_MIN);
            if (fin.hi_y)      out_next.pixel_row = vpp_pkg::PIX_MAX;
            else if (fin.lo_y) out_next.pixel_row = vpp_pkg::PIX_MIN;
            else               out_next.pixel_row = $signed(fin.q_y ^ vpp_pkg::PIX_MIN);
            out_next.clipped = fin.hi_x || fin.lo_x || fin.hi_y || fin.lo_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= dv_valid[vpp_pkg::DIV_STEPS];
        end
        if (out_load && dv_valid[vpp_pkg::DIV_STEPS]) out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // a full pipeline is the only reason to refuse a vertex
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input refused while output not stalled");

    a_zero_w: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.zero_w) |->
        (m_data.pixel_col == '0 && m_data.pixel_row == '0 && !m_data.clipped))
        else $error("zero w result with nonzero fields");

    a_clip_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.clipped) |->
        (m_data.pixel_col == vpp_pkg::PIX_MAX || m_data.pixel_col == vpp_pkg::PIX_MIN ||
         m_data.pixel_row == vpp_pkg::PIX_MAX || m_data.pixel_row == vpp_pkg::PIX_MIN))
        else $error("clipped set with no saturated coordinate");

endmodule
`default_nettype wire
